// ----- rtl/sctint_pkg.sv -----
// Shared types and codes for the sorted curve table interpolator.
package sctint_pkg;

    localparam int DATE_W  = 22;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    localparam logic OP_SET    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_ANSWERED = 2'd0;
    localparam logic [1:0] STATUS_STORED   = 2'd1;
    localparam logic [1:0] STATUS_DROPPED  = 2'd2;

    typedef struct packed {
        logic                       opcode;
        logic [DATE_W-1:0]          point_date;
        logic signed [VALUE_W-1:0]  point_value;
    } sctint_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value_out;
        logic [1:0]                 status;
        logic [COUNT_W-1:0]         entry_count;
    } sctint_rsp_t;

    // divider command: magnitude of numerator, divisor, sign of quotient
    typedef struct packed {
        logic        go;
        logic        neg;
        logic [63:0] num;
        logic [22:0] den;
    } sctint_div_cmd_t;

endpackage

// ----- rtl/sorted_curve_table_interpolator_unit.sv -----
// Top level: sorted point table in two memories, sequencer and divider.
//
// Usage: pulse start with a request on req while busy is low. The block
// raises busy until the single result appears on rsp for one cycle,
// marked by done. The receiver cannot stall; results must be taken then.
// cfg_we/cfg_data write the curve start date; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// A request walks the table in order through the registered memory read
// port, with a read state and a compare state per entry visited; an
// insert then shifts each later entry up one slot, read then write.
// An interpolating lookup also waits on the bit-serial divider (one
// quotient bit a cycle). busy stays high through the done cycle, so the
// next request is taken no earlier than the cycle after done.
// Reset empties the table (count to zero, start date zero); the table
// memories themselves are not cleared and need no clearing pass.
module sorted_curve_table_interpolator_unit
    import sctint_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sctint_req_t         req,
    output logic                busy,
    output logic                done,
    output sctint_rsp_t         rsp,
    input  logic                cfg_we,
    input  logic [DATE_W-1:0]   cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR, S_PUT,
        S_PREV, S_PREV_CHK, S_MUL, S_GO, S_DIV, S_ADD, S_RESP
    } state_t;

    state_t                     state_reg;
    logic [CW-1:0]              count_reg;
    logic [DATE_W-1:0]          start_date_reg;
    sctint_req_t                req_reg;
    logic [CW-1:0]              idx_reg;
    logic [CW-1:0]              sh_reg;
    logic                       done_reg;
    sctint_rsp_t                rsp_reg;
    logic [DATE_W-1:0]          d1_reg;
    logic signed [VALUE_W-1:0]  v1_reg;
    logic signed [VALUE_W-1:0]  v0_reg;
    logic [DATE_W-1:0]          d0_reg;
    logic signed [VALUE_W:0]    dv_reg;
    logic [63:0]                prod_reg;
    logic                       neg_reg;
    logic [22:0]                den_reg;

    // table memories
    logic [DATE_W-1:0]          date_mem [TABLE_DEPTH];
    logic signed [VALUE_W-1:0]  value_mem [TABLE_DEPTH];
    logic [DATE_W-1:0]          rd_date;
    logic signed [VALUE_W-1:0]  rd_value;
    logic [AW-1:0]              rd_addr;
    logic                       we;
    logic [AW-1:0]              wr_addr;
    logic [DATE_W-1:0]          wr_date;
    logic signed [VALUE_W-1:0]  wr_value;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            date_mem[wr_addr]  <= wr_date;
            value_mem[wr_addr] <= wr_value;
        end
        rd_date  <= date_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
    end

    sctint_div_cmd_t div_cmd;
    logic            div_done;
    logic [63:0]     div_quot;

    sctint_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .done  (div_done),
        .quot  (div_quot)
    );

    logic [CW-1:0] sh_dec;
    assign sh_dec = sh_reg - CW'(1);

    always_comb
    begin
        rd_addr  = idx_reg[AW-1:0];
        we       = 1'b0;
        wr_addr  = idx_reg[AW-1:0];
        wr_date  = req_reg.point_date;
        wr_value = req_reg.point_value;
        unique case (state_reg)
            S_SHIFT_RD: rd_addr = sh_dec[AW-1:0];
            S_SHIFT_WR:
            begin
                we       = 1'b1;
                wr_addr  = sh_reg[AW-1:0];
                wr_date  = rd_date;
                wr_value = rd_value;
            end
            S_PUT: we = 1'b1;
            default: ;
        endcase
        // launch once the registered product is valid
        div_cmd.go  = (state_reg == S_GO);
        div_cmd.neg = neg_reg;
        div_cmd.num = prod_reg;
        div_cmd.den = den_reg;
    end

    // signed product of date offset and value step, held as magnitude
    logic signed [DATE_W:0]   dq;
    logic signed [55:0]       prod_s;
    assign dq     = $signed({1'b0, req_reg.point_date}) - $signed({1'b0, d0_reg});
    assign prod_s = dq * dv_reg;

    logic [63:0] sum_w;
    assign sum_w = 64'($signed(v0_reg)) + div_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            start_date_reg <= '0;
            done_reg       <= 1'b0;
            idx_reg        <= '0;
            sh_reg         <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                start_date_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && !busy)
                    begin
                        req_reg <= req;
                        idx_reg <= '0;
                        if (req.opcode == OP_LOOKUP &&
                            (req.point_date <= start_date_reg || count_reg == '0))
                        begin
                            rsp_reg.value_out <= '0;
                            rsp_reg.status    <= STATUS_ANSWERED;
                            state_reg         <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // read of entry idx in flight
                    if (idx_reg == count_reg)
                    begin
                        if (req_reg.opcode == OP_LOOKUP)
                        begin
                            idx_reg   <= idx_reg - CW'(1);
                            state_reg <= S_PREV;
                        end
                        else if (count_reg == CW'(TABLE_DEPTH))
                        begin
                            rsp_reg.value_out <= '0;
                            rsp_reg.status    <= STATUS_DROPPED;
                            state_reg         <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_PUT;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK:
                begin
                    if (rd_date >= req_reg.point_date)
                    begin
                        d1_reg <= rd_date;
                        v1_reg <= rd_value;
                        if (req_reg.opcode == OP_LOOKUP)
                        begin
                            if (rd_date == req_reg.point_date || idx_reg == '0)
                            begin
                                rsp_reg.value_out <= rd_value;
                                rsp_reg.status    <= STATUS_ANSWERED;
                                state_reg         <= S_RESP;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg - CW'(1);
                                state_reg <= S_PREV;
                            end
                        end
                        else if (rd_date == req_reg.point_date)
                        begin
                            state_reg <= S_PUT;
                        end
                        else if (count_reg == CW'(TABLE_DEPTH))
                        begin
                            rsp_reg.value_out <= '0;
                            rsp_reg.status    <= STATUS_DROPPED;
                            state_reg         <= S_RESP;
                        end
                        else
                        begin
                            sh_reg    <= count_reg;
                            state_reg <= S_SHIFT_RD;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SHIFT_RD:
                begin
                    state_reg <= S_SHIFT_WR;
                end
                S_SHIFT_WR:
                begin
                    // move entry sh-1 up to sh
                    sh_reg <= sh_dec;
                    if (sh_dec == idx_reg)
                    begin
                        state_reg <= S_PUT;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_RD;
                    end
                end
                S_PUT:
                begin
                    if (d1_reg != req_reg.point_date || idx_reg == count_reg)
                    begin
                        count_reg         <= count_reg + CW'(1);
                        rsp_reg.entry_count <= COUNT_W'(count_reg + CW'(1));
                    end
                    rsp_reg.value_out <= '0;
                    rsp_reg.status    <= STATUS_STORED;
                    state_reg         <= S_RESP;
                end
                S_PREV:
                begin
                    state_reg <= S_PREV_CHK;
                end
                S_PREV_CHK:
                begin
                    if (idx_reg == count_reg - CW'(1) &&
                        rd_date < req_reg.point_date)
                    begin
                        // query past the last point
                        rsp_reg.value_out <= rd_value;
                        rsp_reg.status    <= STATUS_ANSWERED;
                        state_reg         <= S_RESP;
                    end
                    else
                    begin
                        d0_reg    <= rd_date;
                        v0_reg    <= rd_value;
                        dv_reg    <= $signed({v1_reg[VALUE_W-1], v1_reg})
                                   - $signed({rd_value[VALUE_W-1], rd_value});
                        den_reg   <= 23'({1'b0, d1_reg} - {1'b0, rd_date});
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_GO;
                end
                S_GO:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    rsp_reg.value_out <= sum_w[VALUE_W-1:0];
                    rsp_reg.status    <= STATUS_ANSWERED;
                    state_reg         <= S_RESP;
                end
                S_RESP:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_IDLE)
            begin
                rsp_reg.entry_count <= COUNT_W'(count_reg);
            end
        end
    end

    // magnitude and sign of the product, registered before the divider
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PREV_CHK || state_reg == S_MUL)
        begin
            if (state_reg == S_MUL)
            begin
                prod_reg <= 64'(prod_s[55] ? -prod_s : prod_s);
                neg_reg  <= prod_s[55];
            end
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- rtl/sctint_div.sv -----
// Restoring divider: 64-bit magnitude by 23-bit divisor, one quotient bit per cycle.
module sctint_div
    import sctint_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  sctint_div_cmd_t cmd,
    output logic            done,
    output logic [63:0]     quot
);

    logic [63:0] q_reg;
    logic [23:0] rem_reg;
    logic [22:0] den_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [23:0] shifted;
    logic [24:0] diff;

    assign shifted = {rem_reg[22:0], q_reg[63]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            q_reg   <= cmd.num;
            rem_reg <= '0;
            den_reg <= cmd.den;
            neg_reg <= cmd.neg;
        end
        else if (run_reg)
        begin
            if (!diff[24])
            begin
                rem_reg <= diff[23:0];
                q_reg   <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? (~q_reg + 64'd1) : q_reg;

endmodule

// ----- rtl/sctint_checker.sv -----
// Port-level checks for the interpolator, bound to the top level.
module sctint_checker
    import sctint_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input sctint_rsp_t rsp
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done without busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("request not taken");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == STATUS_ANSWERED || rsp.status == STATUS_STORED ||
                  rsp.status == STATUS_DROPPED)) else $error("bad status");

    a_set_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != STATUS_ANSWERED) |-> rsp.value_out == '0)
        else $error("set result not zero");

endmodule

bind sorted_curve_table_interpolator_unit sctint_checker u_sctint_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

// ----- verif/tb_top.sv -----
// Self-checking bench for the sorted curve table interpolator: scoreboard class plus drivers.

class curve_scoreboard;
    localparam int DEPTH = 64;

    logic [21:0]        start_date;
    logic [21:0]        dates [DEPTH];
    logic signed [31:0] values [DEPTH];
    int                 held;
    sctint_pkg::sctint_rsp_t pending_rsp [$];
    int                 errors;
    int                 n_lookup;
    int                 n_interp;
    int                 n_dropped;
    int                 n_checked;

    function new();
        start_date = '0;
        held       = 0;
        errors     = 0;
        n_lookup   = 0;
        n_interp   = 0;
        n_dropped  = 0;
        n_checked  = 0;
    endfunction

    function logic signed [31:0] value_at(logic [21:0] q);
        longint d0;
        longint d1;
        longint v0;
        longint v1;
        longint num;
        if (q <= start_date || held == 0)
            return '0;
        for (int i = 0; i < held; i++)
        begin
            if (dates[i] >= q)
            begin
                if (dates[i] == q || i == 0)
                    return values[i];
                d0  = longint'(dates[i-1]);
                d1  = longint'(dates[i]);
                v0  = longint'(values[i-1]);
                v1  = longint'(values[i]);
                num = (longint'(q) - d0) * (v1 - v0);
                n_interp++;
                // SV division truncates toward zero, as required
                return 32'(v0 + num / (d1 - d0));
            end
        end
        return values[held-1];
    endfunction

    function logic [1:0] place_point(logic [21:0] d, logic signed [31:0] v);
        int i;
        i = 0;
        while (i < held && dates[i] < d)
            i++;
        if (i < held && dates[i] == d)
        begin
            values[i] = v;
            return sctint_pkg::STATUS_STORED;
        end
        if (held >= DEPTH)
        begin
            n_dropped++;
            return sctint_pkg::STATUS_DROPPED;
        end
        for (int j = held; j > i; j--)
        begin
            dates[j]  = dates[j-1];
            values[j] = values[j-1];
        end
        dates[i]  = d;
        values[i] = v;
        held++;
        return sctint_pkg::STATUS_STORED;
    endfunction

    function void note_request(sctint_pkg::sctint_req_t r);
        sctint_pkg::sctint_rsp_t e;
        e.value_out = '0;
        if (r.opcode == sctint_pkg::OP_LOOKUP)
        begin
            n_lookup++;
            e.value_out = value_at(r.point_date);
            e.status    = sctint_pkg::STATUS_ANSWERED;
        end
        else
            e.status = place_point(r.point_date, r.point_value);
        e.entry_count = 7'(held);
        pending_rsp.push_back(e);
    endfunction

    function void check_result(sctint_pkg::sctint_rsp_t got);
        sctint_pkg::sctint_rsp_t e;
        if (pending_rsp.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
            errors++;
            return;
        end
        e = pending_rsp.pop_front();
        n_checked++;
        if (got.value_out !== e.value_out)
        begin
            $display("%0t: value_out mismatch: expected %h, actual %h",
                     $time, e.value_out, got.value_out);
            errors++;
        end
        if (got.status !== e.status)
        begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, e.status, got.status);
            errors++;
        end
        if (got.entry_count !== e.entry_count)
        begin
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, e.entry_count, got.entry_count);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import sctint_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;

    logic        clk;
    logic        rst_n;
    logic        start;
    sctint_req_t req;
    logic        busy;
    logic        done;
    sctint_rsp_t rsp;
    logic        cfg_we;
    logic [DATE_W-1:0] cfg_data;

    curve_scoreboard board;
    int idle_cycles;
    int n_sent;
    logic [21:0] known_dates [$];

    sorted_curve_table_interpolator_unit #(.TABLE_DEPTH(64)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .busy     (busy),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_result(rsp);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_request(logic op, logic [21:0] d, logic signed [31:0] v);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            // drop start while idling between requests
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.opcode      = op;
        req.point_date  = d;
        req.point_value = v;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(req);
        n_sent++;
        if (op == OP_SET)
            known_dates.push_back(d);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (board.pending_rsp.size() != 0 || busy)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_start_date(logic [21:0] d);
        wait_drained();
        cfg_data <= d;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
        board.start_date = d;
    endtask

    function automatic logic [21:0] pick_date(logic [21:0] base, int span);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && known_dates.size() != 0)
            return known_dates[$urandom_range(0, known_dates.size() - 1)];
        if (r == 4)
            return 22'($urandom);
        return base + 22'($urandom_range(0, span));
    endfunction

    // mix random lookups with sets, which overwrite, insert or drop when full
    task automatic random_phase(int n_items, logic [21:0] base, int span);
        logic signed [31:0] v;
        for (int k = 0; k < n_items; k++)
        begin
            v = $urandom;
            if ($urandom_range(0, 7) == 0)
                v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            if ($urandom_range(0, 2) == 0)
                send_request(OP_SET, pick_date(base, span), v);
            else
                send_request(OP_LOOKUP, pick_date(base, span), v);
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        idle_cycles = 0;
        n_sent      = 0;
        board       = new();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table, extremes of date and value
        send_request(OP_LOOKUP, 22'h3fffff, 32'sh0);
        send_request(OP_LOOKUP, 22'h0, 32'sh0);
        send_request(OP_SET, 22'd100, 32'sh7fffffff);
        send_request(OP_SET, 22'd300, 32'sh80000000);
        send_request(OP_SET, 22'd0, 32'sh01000000);
        send_request(OP_SET, 22'h3fffff, -32'sh00000001);
        send_request(OP_SET, 22'd200, 32'sh12345678);
        send_request(OP_SET, 22'd200, -32'sh12345678);
        send_request(OP_LOOKUP, 22'd0, 32'sh0);
        send_request(OP_LOOKUP, 22'd1, 32'sh0);
        send_request(OP_LOOKUP, 22'd100, 32'sh0);
        send_request(OP_LOOKUP, 22'd150, 32'sh0);
        send_request(OP_LOOKUP, 22'd250, 32'sh0);
        send_request(OP_LOOKUP, 22'd299, 32'sh0);
        send_request(OP_LOOKUP, 22'h3ffffe, 32'sh0);
        send_request(OP_LOOKUP, 22'h3fffff, 32'sh0);

        write_start_date(22'd150);
        send_request(OP_LOOKUP, 22'd150, 32'sh0);
        send_request(OP_LOOKUP, 22'd151, 32'sh0);
        write_start_date(22'h3fffff);
        send_request(OP_LOOKUP, 22'h3fffff, 32'sh0);
        write_start_date(22'd0);

        // fill to capacity, then overwrite and drop at full, then random traffic
        for (int k = 0; board.held < 64; k++)
            send_request(OP_SET, 22'($urandom), $urandom);
        send_request(OP_SET, known_dates[3], 32'sh0badf00d);
        send_request(OP_SET, 22'd5, 32'sh0);
        for (int k = 0; k < 150; k++)
            send_request($urandom_range(0, 3) == 0 ? OP_SET : OP_LOOKUP,
                         pick_date(22'd0, 4194303), $urandom);

        // fresh small tables would need a reset; instead vary start date on
        // the full table, then keep going with random traffic
        write_start_date(22'($urandom));
        random_phase(400, 22'd0, 4194303);
        write_start_date(22'd1);
        random_phase(500, 22'd0, 4194303);
        write_start_date(22'h200000);
        random_phase(500, 22'h1ff000, 8192);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("sent %0d requests: %0d lookups (%0d interpolated), %0d inserts dropped",
                 n_sent, board.n_lookup, board.n_interp, board.n_dropped);
        $display("checked %0d results, %0d errors", board.n_checked, board.errors);
        if (board.errors == 0 && board.pending_rsp.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/sctint_pkg.sv
rtl/sctint_div.sv
rtl/sorted_curve_table_interpolator_unit.sv
rtl/sctint_checker.sv
verif/tb_top.sv
